// ===== hdl/twca_pkg.sv =====
package twca_pkg;

  localparam int NUM_CHAN         = 4;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF   = 24;
  localparam int SECONDS_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 8;

  localparam int WIN_BITS      = 16;
  localparam int AVG_BITS      = 24;
  localparam int CFG_ADDR_BITS = 4;

  localparam logic [WIN_BITS-1:0] WIN_RESET = 16'd60;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_O2_WIN   = 4'd0,
    REG_CO2_WIN  = 4'd1,
    REG_CO_WIN   = 4'd2,
    REG_TEMP_WIN = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                busy;
    logic                upd;
    logic                zero;
    logic [AVG_BITS-1:0] avg;
  } lane_stat_t;

endpackage

// ===== hdl/twca_if.sv =====
interface twca_in_if #(
  parameter int SAMPLE_BITS = twca_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [SAMPLE_BITS-1:0] o2_sample;
  logic [SAMPLE_BITS-1:0] co2_sample;
  logic [SAMPLE_BITS-1:0] co_sample;
  logic [SAMPLE_BITS-1:0] temp_sample;

  modport source (output valid, cmd, o2_sample, co2_sample, co_sample, temp_sample,
                  input ready);
  modport sink (input valid, cmd, o2_sample, co2_sample, co_sample, temp_sample,
                output ready);
endinterface

interface twca_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [twca_pkg::NUM_CHAN-1:0]        avg_update_mask;
  logic [twca_pkg::NUM_CHAN-1:0]        avg_zero_count_mask;
  logic [twca_pkg::AVG_BITS-1:0]        o2_average;
  logic [twca_pkg::AVG_BITS-1:0]        co2_average;
  logic [twca_pkg::AVG_BITS-1:0]        co_average;
  logic [twca_pkg::AVG_BITS-1:0]        temp_average;

  modport source (output valid, avg_update_mask, avg_zero_count_mask, o2_average,
                  co2_average, co_average, temp_average, input ready);
  modport sink (input valid, avg_update_mask, avg_zero_count_mask, o2_average,
                co2_average, co_average, temp_average, output ready);
endinterface

interface twca_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [twca_pkg::CFG_ADDR_BITS-1:0] index;
  logic [twca_pkg::WIN_BITS-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/timed_window_channel_averager_core.sv =====
// Four-channel timed-window averager (o2, co2, co, temp).
// in_ch: one transaction is either a one-second tick (cmd = 1) or a sample
//   frame (cmd = 0) carrying four readings. out_ch: one transaction per
//   input transaction, with the update and zero-count masks and the four
//   held averages in unsigned 16.8 fixed point. cfg_ch: window length per
//   channel in seconds, indices 0..3; other indices are dropped. cfg_ch is
//   always ready; write it only while no input transaction is in flight.
// Path: a tick, or a frame where no window closes with samples, passes
//   through the lane registers into the output register. A closing window
//   runs each lane's bit-serial divider on a SAMPLE_BITS+COUNT_BITS+FRAC_BITS
//   bit dividend (48 by default), all four lanes in parallel, and the result
//   is moved into the output register once every lane has finished.
// Throughput: one item is in work at a time; in_ch.ready returns once the
//   result is moved into the output register, so the next item may be taken
//   while the previous result still waits for out_ch.ready.
// Reset: all counters, sums and held averages clear, windows return to 60 s.
// A stalled receiver holds the result; at most one more item is processed
//   behind it before in_ch.ready stays low.
module timed_window_channel_averager_core #(
  parameter int SAMPLE_BITS  = twca_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS   = twca_pkg::COUNT_BITS_DEF,
  parameter int SECONDS_BITS = twca_pkg::SECONDS_BITS_DEF,
  parameter int FRAC_BITS    = twca_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  twca_in_if.sink    in_ch,
  twca_out_if.source out_ch,
  twca_cfg_if.sink   cfg_ch
);

  logic [twca_pkg::WIN_BITS-1:0] window_r [twca_pkg::NUM_CHAN];
  logic [twca_pkg::WIN_BITS-1:0] window_nxt [twca_pkg::NUM_CHAN];
  logic [SAMPLE_BITS-1:0]        sample [twca_pkg::NUM_CHAN];
  twca_pkg::lane_stat_t          stat [twca_pkg::NUM_CHAN];
  logic                          idle;
  logic                          accept;
  logic [twca_pkg::NUM_CHAN-1:0] lane_busy;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = idle;
  assign accept       = in_ch.valid && in_ch.ready;

  assign sample[0] = in_ch.o2_sample;
  assign sample[1] = in_ch.co2_sample;
  assign sample[2] = in_ch.co_sample;
  assign sample[3] = in_ch.temp_sample;

  always_comb begin
    for (int c = 0; c < twca_pkg::NUM_CHAN; c++) begin
      window_nxt[c] = window_r[c];
    end
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        twca_pkg::REG_O2_WIN:   window_nxt[0] = cfg_ch.data;
        twca_pkg::REG_CO2_WIN:  window_nxt[1] = cfg_ch.data;
        twca_pkg::REG_CO_WIN:   window_nxt[2] = cfg_ch.data;
        twca_pkg::REG_TEMP_WIN: window_nxt[3] = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < twca_pkg::NUM_CHAN; c++) begin
        window_r[c] <= twca_pkg::WIN_RESET;
      end
    end else begin
      for (int c = 0; c < twca_pkg::NUM_CHAN; c++) begin
        window_r[c] <= window_nxt[c];
      end
    end
  end

  for (genvar g = 0; g < twca_pkg::NUM_CHAN; g++) begin : g_lane
    twca_lane #(
      .SAMPLE_BITS  (SAMPLE_BITS),
      .COUNT_BITS   (COUNT_BITS),
      .SECONDS_BITS (SECONDS_BITS),
      .FRAC_BITS    (FRAC_BITS)
    ) u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .start  (accept),
      .cmd    (in_ch.cmd),
      .sample (sample[g]),
      .window (window_r[g]),
      .stat   (stat[g])
    );
    assign lane_busy[g] = stat[g].busy;
  end

  twca_merge u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .stat   (stat),
    .idle   (idle),
    .out_ch (out_ch)
  );

  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ch.ready)
    else $error("input taken while previous transaction still in work");

  a_busy_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_busy != '0) |-> !in_ch.ready)
    else $error("divider running with no transaction pending");

  a_zero_in_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.avg_zero_count_mask & ~out_ch.avg_update_mask) == '0))
    else $error("zero-count flag without update");

  a_zero_avg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.avg_zero_count_mask[0]) |-> (out_ch.o2_average == '0))
    else $error("empty window reported a nonzero average");

  a_tick_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.cmd == twca_pkg::CMD_TICK)) |=> ##1 (!out_ch.valid ||
      !$rose(out_ch.valid) || (out_ch.avg_update_mask == '0)))
    else $error("tick produced an average update");

endmodule

// ===== hdl/twca_div.sv =====
module twca_div #(
  parameter int DVD_BITS = 48,
  parameter int DVS_BITS = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0] divisor,
  output logic                busy,
  output logic                fin,
  output logic [DVD_BITS-1:0] quot_nxt
);

  localparam int CNT_W = (DVD_BITS > 1) ? $clog2(DVD_BITS) : 1;

  logic [DVD_BITS-1:0] dvd_r, dvd_nxt;
  logic [DVS_BITS-1:0] rem_r, rem_nxt;
  logic [DVS_BITS-1:0] dvs_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic [DVS_BITS:0]   trial;
  logic                qbit;

  // restoring step: quotient bits shift into the dividend register
  always_comb begin
    trial   = {rem_r, dvd_r[DVD_BITS-1]};
    qbit    = (trial >= {1'b0, dvs_r});
    rem_nxt = qbit ? DVS_BITS'(trial - {1'b0, dvs_r}) : DVS_BITS'(trial);
    dvd_nxt = {dvd_r[DVD_BITS-2:0], qbit};
  end

  assign busy     = busy_r;
  assign fin      = busy_r && (cnt_r == CNT_W'(DVD_BITS - 1));
  assign quot_nxt = dvd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (fin) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// ===== hdl/twca_lane.sv =====
module twca_lane #(
  parameter int SAMPLE_BITS  = twca_pkg::SAMPLE_BITS_DEF,
  parameter int COUNT_BITS   = twca_pkg::COUNT_BITS_DEF,
  parameter int SECONDS_BITS = twca_pkg::SECONDS_BITS_DEF,
  parameter int FRAC_BITS    = twca_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          cmd,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic [twca_pkg::WIN_BITS-1:0] window,
  output twca_pkg::lane_stat_t          stat
);

  localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
  localparam int DVD_BITS   = SUM_BITS + FRAC_BITS;
  localparam int CMP_BITS   = (SECONDS_BITS > twca_pkg::WIN_BITS) ? SECONDS_BITS
                                                                  : twca_pkg::WIN_BITS;
  localparam int CLAMP_BITS = (DVD_BITS > twca_pkg::AVG_BITS) ? DVD_BITS
                                                              : twca_pkg::AVG_BITS;

  logic [SECONDS_BITS-1:0]       elapsed_r, elapsed_nxt;
  logic [SUM_BITS-1:0]           sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]         count_r, count_nxt;
  logic [twca_pkg::AVG_BITS-1:0] avg_r, avg_nxt;
  logic                          upd_r, upd_nxt;
  logic                          zero_r, zero_nxt;

  logic [CMP_BITS-1:0]           elapsed_ext, win_ext;
  logic                          div_start, div_busy, div_fin;
  logic [DVD_BITS-1:0]           div_quot;
  logic [CLAMP_BITS-1:0]         quot_ext, avg_max_ext;
  logic [twca_pkg::AVG_BITS-1:0] avg_clamped;

  twca_div #(
    .DVD_BITS(DVD_BITS),
    .DVS_BITS(COUNT_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DVD_BITS'(sum_r) << FRAC_BITS),
    .divisor  (count_r),
    .busy     (div_busy),
    .fin      (div_fin),
    .quot_nxt (div_quot)
  );

  always_comb begin
    quot_ext    = CLAMP_BITS'(div_quot);
    avg_max_ext = CLAMP_BITS'({twca_pkg::AVG_BITS{1'b1}});
    avg_clamped = (quot_ext > avg_max_ext) ? {twca_pkg::AVG_BITS{1'b1}}
                                           : twca_pkg::AVG_BITS'(quot_ext);
  end

  always_comb begin
    elapsed_ext = CMP_BITS'(elapsed_r);
    win_ext     = CMP_BITS'(window);
    elapsed_nxt = elapsed_r;
    sum_nxt     = sum_r;
    count_nxt   = count_r;
    avg_nxt     = avg_r;
    upd_nxt     = upd_r;
    zero_nxt    = zero_r;
    div_start   = 1'b0;
    if (start) begin
      upd_nxt  = 1'b0;
      zero_nxt = 1'b0;
      if (cmd == twca_pkg::CMD_TICK) begin
        if (elapsed_r != {SECONDS_BITS{1'b1}}) begin
          elapsed_nxt = elapsed_r + 1'b1;
        end
      end else if (elapsed_ext < win_ext) begin
        if (count_r != {COUNT_BITS{1'b1}}) begin
          sum_nxt   = sum_r + SUM_BITS'(sample);
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (elapsed_ext == win_ext) begin
          upd_nxt = 1'b1;
          if (count_r == '0) begin
            zero_nxt = 1'b1;
            avg_nxt  = '0;
          end else begin
            div_start = 1'b1;
          end
        end
        elapsed_nxt = '0;
        sum_nxt     = '0;
        count_nxt   = '0;
      end
    end
    if (div_fin) begin
      avg_nxt = avg_clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      sum_r     <= '0;
      count_r   <= '0;
      avg_r     <= '0;
      upd_r     <= 1'b0;
      zero_r    <= 1'b0;
    end else begin
      elapsed_r <= elapsed_nxt;
      sum_r     <= sum_nxt;
      count_r   <= count_nxt;
      avg_r     <= avg_nxt;
      upd_r     <= upd_nxt;
      zero_r    <= zero_nxt;
    end
  end

  assign stat.busy = div_busy;
  assign stat.upd  = upd_r;
  assign stat.zero = zero_r;
  assign stat.avg  = avg_r;

endmodule

// ===== hdl/twca_merge.sv =====
module twca_merge (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  twca_pkg::lane_stat_t stat [twca_pkg::NUM_CHAN],
  output logic                 idle,
  twca_out_if.source           out_ch
);

  logic                          pend_r, pend_nxt;
  logic                          valid_r, valid_nxt;
  logic [twca_pkg::NUM_CHAN-1:0] upd_mask_r, zero_mask_r;
  logic [twca_pkg::AVG_BITS-1:0] avg_r [twca_pkg::NUM_CHAN];
  logic [twca_pkg::NUM_CHAN-1:0] lane_busy;
  logic                          load;

  always_comb begin
    for (int c = 0; c < twca_pkg::NUM_CHAN; c++) begin
      lane_busy[c] = stat[c].busy;
    end
    load      = pend_r && (lane_busy == '0) && (!valid_r || out_ch.ready);
    pend_nxt  = accept ? 1'b1 : (load ? 1'b0 : pend_r);
    valid_nxt = load ? 1'b1 : (out_ch.ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      pend_r  <= pend_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int c = 0; c < twca_pkg::NUM_CHAN; c++) begin
        upd_mask_r[c]  <= stat[c].upd;
        zero_mask_r[c] <= stat[c].zero;
        avg_r[c]       <= stat[c].avg;
      end
    end
  end

  assign idle                       = !pend_r;
  assign out_ch.valid               = valid_r;
  assign out_ch.avg_update_mask     = upd_mask_r;
  assign out_ch.avg_zero_count_mask = zero_mask_r;
  assign out_ch.o2_average          = avg_r[0];
  assign out_ch.co2_average         = avg_r[1];
  assign out_ch.co_average          = avg_r[2];
  assign out_ch.temp_average        = avg_r[3];

endmodule

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SUM_BITS = twca_pkg::SAMPLE_BITS_DEF + twca_pkg::COUNT_BITS_DEF;
  localparam int DIV_CYCLES = twca_pkg::SAMPLE_BITS_DEF + twca_pkg::COUNT_BITS_DEF
                              + twca_pkg::FRAC_BITS_DEF;
  localparam int SETTLE_CYCLES = DIV_CYCLES + 8;
  localparam logic [twca_pkg::SECONDS_BITS_DEF-1:0] SEC_MAX = '1;
  localparam logic [twca_pkg::COUNT_BITS_DEF-1:0] CNT_MAX = '1;
  localparam logic [twca_pkg::AVG_BITS-1:0] AVG_MAX = '1;
  localparam logic [twca_pkg::CFG_ADDR_BITS-1:0] SPARE_REG_LO = 4'd4;
  localparam logic [twca_pkg::CFG_ADDR_BITS-1:0] SPARE_REG_HI = 4'd15;

  typedef struct packed {
    logic                                                         cmd;
    logic [twca_pkg::NUM_CHAN-1:0][twca_pkg::SAMPLE_BITS_DEF-1:0] reading;
  } frame_t;

  typedef struct packed {
    logic [twca_pkg::NUM_CHAN-1:0]                         upd_mask;
    logic [twca_pkg::NUM_CHAN-1:0]                         zero_mask;
    logic [twca_pkg::NUM_CHAN-1:0][twca_pkg::AVG_BITS-1:0] avgs;
  } averages_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  twca_in_if  in_bus();
  twca_out_if out_bus();
  twca_cfg_if cfg_bus();

  timed_window_channel_averager_core uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_bus),
    .out_ch(out_bus),
    .cfg_ch(cfg_bus)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model state
  logic [twca_pkg::WIN_BITS-1:0]         window_len [twca_pkg::NUM_CHAN];
  logic [twca_pkg::SECONDS_BITS_DEF-1:0] elapsed    [twca_pkg::NUM_CHAN];
  logic [SUM_BITS-1:0]                   run_sum    [twca_pkg::NUM_CHAN];
  logic [twca_pkg::COUNT_BITS_DEF-1:0]   n_samples  [twca_pkg::NUM_CHAN];
  logic [twca_pkg::AVG_BITS-1:0]         held_avg   [twca_pkg::NUM_CHAN];

  string lane_name [twca_pkg::NUM_CHAN] = '{"o2", "co2", "co", "temp"};

  frame_t    pending_frames [$];
  averages_t expected_avgs  [$];
  frame_t    in_flight;
  int        errors = 0;
  bit        no_idle = 1'b0;
  int        in_gap = 0;
  int        in_quiet = 0;
  int        out_stall = 0;
  int        out_quiet = 0;

  function automatic averages_t step_averager(frame_t f);
    averages_t r;
    logic [63:0] q, rem, v;
    int c;
    r.upd_mask = '0;
    r.zero_mask = '0;
    if (f.cmd == twca_pkg::CMD_TICK) begin
      for (c = 0; c < twca_pkg::NUM_CHAN; c++)
        if (elapsed[c] != SEC_MAX) elapsed[c]++;
    end else begin
      for (c = 0; c < twca_pkg::NUM_CHAN; c++) begin
        if (elapsed[c] < window_len[c]) begin
          if (n_samples[c] != CNT_MAX) begin
            run_sum[c] += f.reading[c];
            n_samples[c]++;
          end
        end else begin
          if (elapsed[c] == window_len[c]) begin
            r.upd_mask[c] = 1'b1;
            if (n_samples[c] == '0) begin
              r.zero_mask[c] = 1'b1;
              held_avg[c] = '0;
            end else begin
              q = 64'(run_sum[c]) / 64'(n_samples[c]);
              rem = 64'(run_sum[c]) % 64'(n_samples[c]);
              v = (q << twca_pkg::FRAC_BITS_DEF)
                  + ((rem << twca_pkg::FRAC_BITS_DEF) / 64'(n_samples[c]));
              held_avg[c] = (v > 64'(AVG_MAX)) ? AVG_MAX : v[twca_pkg::AVG_BITS-1:0];
            end
          end
          elapsed[c] = '0;
          run_sum[c] = '0;
          n_samples[c] = '0;
        end
      end
    end
    for (c = 0; c < twca_pkg::NUM_CHAN; c++) r.avgs[c] = held_avg[c];
    return r;
  endfunction

  function automatic int pick_gap(inout int quiet_left);
    if (no_idle) return 0;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    case ($urandom_range(0, 19))
      0: begin
        quiet_left = $urandom_range(10, 40);
        return 0;
      end
      1: return $urandom_range(10, 40);
      2, 3, 4, 5, 6, 7: return $urandom_range(1, 3);
      default: return 0;
    endcase
  endfunction

  function automatic logic [twca_pkg::SAMPLE_BITS_DEF-1:0] pick_reading();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return twca_pkg::SAMPLE_BITS_DEF'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        expected_avgs.push_back(step_averager(in_flight));
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_frames.size() != 0) begin
          in_flight = pending_frames.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.cmd <= in_flight.cmd;
          in_bus.o2_sample <= in_flight.reading[0];
          in_bus.co2_sample <= in_flight.reading[1];
          in_bus.co_sample <= in_flight.reading[2];
          in_bus.temp_sample <= in_flight.reading[3];
          in_gap <= pick_gap(in_quiet);
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_mon
    averages_t want;
    logic [twca_pkg::NUM_CHAN-1:0][twca_pkg::AVG_BITS-1:0] seen;
    int c;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_bus.valid === 1'b1 && out_bus.ready) begin
        if (expected_avgs.size() == 0) begin
          report_mismatch("transaction with nothing expected, update mask",
                          32'(out_bus.avg_update_mask), 0);
        end else begin
          want = expected_avgs.pop_front();
          seen = {out_bus.temp_average, out_bus.co_average,
                  out_bus.co2_average, out_bus.o2_average};
          if (out_bus.avg_update_mask !== want.upd_mask)
            report_mismatch("update mask", 32'(out_bus.avg_update_mask),
                            32'(want.upd_mask));
          if (out_bus.avg_zero_count_mask !== want.zero_mask)
            report_mismatch("zero count mask", 32'(out_bus.avg_zero_count_mask),
                            32'(want.zero_mask));
          for (c = 0; c < twca_pkg::NUM_CHAN; c++)
            if (seen[c] !== want.avgs[c])
              report_mismatch($sformatf("%s average", lane_name[c]), 32'(seen[c]),
                              32'(want.avgs[c]));
        end
      end
      if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
        out_stall <= pick_gap(out_quiet);
      end
    end
  end

  task automatic queue_frame(logic cmd, logic [twca_pkg::SAMPLE_BITS_DEF-1:0] r0,
                             logic [twca_pkg::SAMPLE_BITS_DEF-1:0] r1,
                             logic [twca_pkg::SAMPLE_BITS_DEF-1:0] r2,
                             logic [twca_pkg::SAMPLE_BITS_DEF-1:0] r3);
    frame_t f;
    f.cmd = cmd;
    f.reading = {r3, r2, r1, r0};
    pending_frames.push_back(f);
  endtask

  task automatic queue_random(int n, int tick_pct);
    repeat (n)
      queue_frame(($urandom_range(0, 99) < tick_pct) ? twca_pkg::CMD_TICK
                                                     : twca_pkg::CMD_SAMPLE,
                  pick_reading(), pick_reading(), pick_reading(), pick_reading());
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_frames.size() != 0 || in_bus.valid || expected_avgs.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [twca_pkg::CFG_ADDR_BITS-1:0] idx,
                           logic [twca_pkg::WIN_BITS-1:0] val);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= val;
    do @(posedge clk);
    while (cfg_bus.ready !== 1'b1);
    case (idx)
      twca_pkg::REG_O2_WIN, twca_pkg::REG_CO2_WIN, twca_pkg::REG_CO_WIN,
      twca_pkg::REG_TEMP_WIN: window_len[idx[1:0]] = val;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic set_windows(logic [twca_pkg::WIN_BITS-1:0] w0,
                             logic [twca_pkg::WIN_BITS-1:0] w1,
                             logic [twca_pkg::WIN_BITS-1:0] w2,
                             logic [twca_pkg::WIN_BITS-1:0] w3);
    drain();
    write_reg(twca_pkg::REG_O2_WIN, w0);
    write_reg(twca_pkg::REG_CO2_WIN, w1);
    write_reg(twca_pkg::REG_CO_WIN, w2);
    write_reg(twca_pkg::REG_TEMP_WIN, w3);
  endtask

  function automatic logic [twca_pkg::WIN_BITS-1:0] pick_window();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 16'd200;
      default: return twca_pkg::WIN_BITS'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin : stimulus
    int c;
    in_bus.valid = 1'b0;
    in_bus.cmd = twca_pkg::CMD_SAMPLE;
    in_bus.o2_sample = '0;
    in_bus.co2_sample = '0;
    in_bus.co_sample = '0;
    in_bus.temp_sample = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    for (c = 0; c < twca_pkg::NUM_CHAN; c++) begin
      window_len[c] = twca_pkg::WIN_RESET;
      elapsed[c] = '0;
      run_sum[c] = '0;
      n_samples[c] = '0;
      held_avg[c] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset windows of 60 s
    queue_random(100, 50);

    set_windows(16'd0, 16'd1, 16'd2, 16'd3);
    write_reg(SPARE_REG_LO, twca_pkg::WIN_BITS'($urandom));
    write_reg(SPARE_REG_HI, twca_pkg::WIN_BITS'($urandom));
    queue_frame(twca_pkg::CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_frame(twca_pkg::CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_frame(twca_pkg::CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_frame(twca_pkg::CMD_TICK,   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_frame(twca_pkg::CMD_SAMPLE, 16'h0001, 16'h0002, 16'h0003, 16'h0001);
    queue_frame(twca_pkg::CMD_TICK,   16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
    queue_frame(twca_pkg::CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_frame(twca_pkg::CMD_SAMPLE, 16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF);
    queue_frame(twca_pkg::CMD_SAMPLE, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h8000);
    queue_frame(twca_pkg::CMD_SAMPLE, 16'h0001, 16'h5555, 16'h0001, 16'h0001);
    queue_frame(twca_pkg::CMD_TICK,   16'h1234, 16'h1234, 16'h1234, 16'h1234);
    queue_frame(twca_pkg::CMD_SAMPLE, 16'h0001, 16'h0002, 16'h0003, 16'h0004);
    queue_frame(twca_pkg::CMD_TICK,   16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    queue_frame(twca_pkg::CMD_SAMPLE, 16'h7FFF, 16'h8000, 16'hFFFE, 16'h0002);
    queue_frame(twca_pkg::CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_frame(twca_pkg::CMD_SAMPLE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    queue_frame(twca_pkg::CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_frame(twca_pkg::CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_frame(twca_pkg::CMD_TICK,   16'h0000, 16'h0000, 16'h0000, 16'h0000);
    queue_frame(twca_pkg::CMD_SAMPLE, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001);

    repeat (5) begin
      set_windows(pick_window(), pick_window(), pick_window(), pick_window());
      queue_random(50, $urandom_range(25, 60));
    end

    // widest windows, back to back
    set_windows(16'hFFFF, 16'hFFFE, 16'd0, 16'd60);
    no_idle = 1'b1;
    queue_frame(twca_pkg::CMD_SAMPLE, pick_reading(), pick_reading(), pick_reading(),
                pick_reading());
    queue_frame(twca_pkg::CMD_SAMPLE, pick_reading(), pick_reading(), pick_reading(),
                pick_reading());
    queue_random(40, 100);
    queue_frame(twca_pkg::CMD_SAMPLE, pick_reading(), pick_reading(), pick_reading(),
                pick_reading());
    queue_frame(twca_pkg::CMD_SAMPLE, pick_reading(), pick_reading(), pick_reading(),
                pick_reading());
    drain();
    no_idle = 1'b0;

    set_windows(pick_window(), pick_window(), pick_window(), pick_window());
    queue_random(40, 40);
    drain();

    if (errors == 0)
      $display("[timed_window_channel_averager_core] OK");
    else
      $display("[timed_window_channel_averager_core] ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[timed_window_channel_averager_core] ERROR");
    $finish;
  end

endmodule
